// File: rtl/mhb_pkg.sv
// ----------------------------------------------------------------------------
// mhb_pkg
// Shared types, constants and helpers for the 64-bit Murmur hash core.
// ----------------------------------------------------------------------------
`default_nettype none

package mhb_pkg;

    // Mixing multiplier shared by word absorption and finalization.
    localparam logic [31:0] MIX_MUL = 32'h5bd1e995;

    // Shift amounts of the mixing steps.
    localparam int unsigned SHIFT_WORD = 24;
    localparam int unsigned SHIFT_FIN1 = 18;
    localparam int unsigned SHIFT_FIN2 = 22;
    localparam int unsigned SHIFT_FIN3 = 17;
    localparam int unsigned SHIFT_FIN4 = 19;

    // Byte count that marks a full word.
    localparam logic [2:0] FULL_COUNT = 3'd4;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_LANE,
        ST_MERGE,
        ST_PART,
        ST_PART_WB,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_F4,
        ST_OUT
    } state_t;

    // Mask that keeps the valid bytes of a partial tail word (1 to 3 bytes).
    function automatic logic [31:0] tail_mask(input logic [2:0] count);
        logic [31:0] mask;
        begin
            case (count)
                3'd1:    mask = 32'h0000_00ff;
                3'd2:    mask = 32'h0000_ffff;
                3'd3:    mask = 32'h00ff_ffff;
                default: mask = 32'hffff_ffff;
            endcase
            return mask;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/mhb_mul.sv
// ----------------------------------------------------------------------------
// mhb_mul
// Shared constant multiplier: registers the low 32 bits of op times MIX_MUL.
// ----------------------------------------------------------------------------
`default_nettype none

module mhb_mul (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] op,
    output logic      [31:0] prod_reg
);

    logic [31:0] prod_next;

    // One 32x32 multiply per cycle, truncated to 32 bits.
    always_comb begin
        prod_next = op * mhb_pkg::MIX_MUL;
    end

    // Product register, loaded only when the sequencer issues an operation.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/murmur_hash_64b_core.sv
// ----------------------------------------------------------------------------
// murmur_hash_64b_core
// Streaming 64-bit Murmur hash over little-endian 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_*) carries one message word per transaction. The
//   first transaction of a message also carries the total byte length, which
//   is combined with the seed register. s_last_word closes the message and
//   s_byte_count (1 to 3) may mark a partial tail word; zero on the last word
//   mixes no data.
//   The config channel (cfg_*) writes the seed; it is always ready and takes
//   effect at the next message start.
//   The result channel (m_*) carries one 64-bit hash per message.
// Timing:
//   All arithmetic runs through one shared registered multiplier, which sets
//   the rate. A full non-last word passes through accept plus four steps
//   (K1, K2, LANE, MERGE); a last word adds F1 to F4 and OUT, and a partial
//   tail takes PART and PART_WB instead of the four word steps. The hash
//   is registered on leaving OUT. s_ready is high only while the sequencer
//   is idle. A finished hash waits in an output register; a stalled receiver
//   holds the block only when the next hash is ready to be written.
// Reset:
//   Synchronous, active low. Clears the seed, the lanes and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur_hash_64b_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // Input word channel.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_data_word,
    input  wire logic [2:0]  s_byte_count,
    input  wire logic        s_last_word,
    input  wire logic [31:0] s_message_length,
    // Result channel.
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [63:0] m_hash_value
);

    mhb_pkg::state_t state_reg, state_next;

    logic [31:0] seed_reg;
    logic [31:0] lane_high_reg, lane_high_next;
    logic [31:0] lane_low_reg, lane_low_next;
    logic        to_low_reg, to_low_next;
    logic        inside_reg, inside_next;
    logic [31:0] word_reg, word_next;
    logic [2:0]  count_reg, count_next;
    logic        last_reg, last_next;
    logic [31:0] k_reg, k_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] hash_reg, hash_next;

    logic        s_accept;
    logic        out_free;
    logic        full_word;
    logic        mul_en;
    logic [31:0] mul_op;
    logic [31:0] prod;

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == mhb_pkg::ST_IDLE);
    assign s_accept     = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_hash_value = hash_reg;
    assign out_free     = !m_valid_reg || m_ready;

    // A non-last word, or a count of four or more, is a full word.
    assign full_word = !s_last_word || (s_byte_count >= mhb_pkg::FULL_COUNT);

    // Shared multiplier.
    mhb_mul u_mul (
        .aclk     (aclk),
        .en       (mul_en),
        .op       (mul_op),
        .prod_reg (prod)
    );

    // Seed register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            seed_reg <= cfg_data;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mhb_pkg::ST_IDLE;
            lane_high_reg <= 32'd0;
            lane_low_reg  <= 32'd0;
            to_low_reg    <= 1'b0;
            inside_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lane_high_reg <= lane_high_next;
            lane_low_reg  <= lane_low_next;
            to_low_reg    <= to_low_next;
            inside_reg    <= inside_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        count_reg <= count_next;
        last_reg  <= last_next;
        k_reg     <= k_next;
        hash_reg  <= hash_next;
    end

    // Sequencer: next state, lane updates and multiplier operand.
    always_comb begin
        state_next     = state_reg;
        lane_high_next = lane_high_reg;
        lane_low_next  = lane_low_reg;
        to_low_next    = to_low_reg;
        inside_next    = inside_reg;
        word_next      = word_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        m_valid_next   = m_valid_reg;
        hash_next      = hash_reg;
        mul_en         = 1'b0;
        mul_op         = word_reg;

        // The receiver takes the pending hash.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            mhb_pkg::ST_IDLE: begin
                if (s_accept) begin
                    word_next  = s_data_word;
                    count_next = s_byte_count;
                    last_next  = s_last_word;
                    // A new message starts the lanes from seed and length.
                    if (!inside_reg) begin
                        lane_high_next = seed_reg ^ s_message_length;
                        lane_low_next  = 32'd0;
                        to_low_next    = 1'b0;
                        inside_next    = 1'b1;
                    end
                    if (full_word) begin
                        state_next = mhb_pkg::ST_K1;
                    end else if (s_byte_count != 3'd0) begin
                        state_next = mhb_pkg::ST_PART;
                    end else begin
                        state_next = mhb_pkg::ST_F1;
                    end
                end
            end
            mhb_pkg::ST_K1: begin
                mul_en     = 1'b1;
                mul_op     = word_reg;
                state_next = mhb_pkg::ST_K2;
            end
            mhb_pkg::ST_K2: begin
                mul_en     = 1'b1;
                mul_op     = prod ^ (prod >> mhb_pkg::SHIFT_WORD);
                state_next = mhb_pkg::ST_LANE;
            end
            mhb_pkg::ST_LANE: begin
                k_next     = prod;
                mul_en     = 1'b1;
                mul_op     = to_low_reg ? lane_low_reg : lane_high_reg;
                state_next = mhb_pkg::ST_MERGE;
            end
            mhb_pkg::ST_MERGE: begin
                if (to_low_reg) begin
                    lane_low_next = prod ^ k_reg;
                end else begin
                    lane_high_next = prod ^ k_reg;
                end
                to_low_next = !to_low_reg;
                state_next  = last_reg ? mhb_pkg::ST_F1 : mhb_pkg::ST_IDLE;
            end
            mhb_pkg::ST_PART: begin
                mul_en     = 1'b1;
                mul_op     = lane_low_reg ^ (word_reg & mhb_pkg::tail_mask(count_reg));
                state_next = mhb_pkg::ST_PART_WB;
            end
            mhb_pkg::ST_PART_WB: begin
                lane_low_next = prod;
                state_next    = mhb_pkg::ST_F1;
            end
            mhb_pkg::ST_F1: begin
                mul_en     = 1'b1;
                mul_op     = lane_high_reg ^ (lane_low_reg >> mhb_pkg::SHIFT_FIN1);
                state_next = mhb_pkg::ST_F2;
            end
            mhb_pkg::ST_F2: begin
                lane_high_next = prod;
                mul_en         = 1'b1;
                mul_op         = lane_low_reg ^ (prod >> mhb_pkg::SHIFT_FIN2);
                state_next     = mhb_pkg::ST_F3;
            end
            mhb_pkg::ST_F3: begin
                lane_low_next = prod;
                mul_en        = 1'b1;
                mul_op        = lane_high_reg ^ (prod >> mhb_pkg::SHIFT_FIN3);
                state_next    = mhb_pkg::ST_F4;
            end
            mhb_pkg::ST_F4: begin
                lane_high_next = prod;
                mul_en         = 1'b1;
                mul_op         = lane_low_reg ^ (prod >> mhb_pkg::SHIFT_FIN4);
                state_next     = mhb_pkg::ST_OUT;
            end
            mhb_pkg::ST_OUT: begin
                // Wait until the output register is free, then close the message.
                if (out_free) begin
                    hash_next      = {lane_high_reg, prod};
                    m_valid_next   = 1'b1;
                    lane_high_next = 32'd0;
                    lane_low_next  = 32'd0;
                    to_low_next    = 1'b0;
                    inside_next    = 1'b0;
                    state_next     = mhb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mhb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mhb_checker.sv
// ----------------------------------------------------------------------------
// mhb_checker
// Port-level checks for the Murmur hash core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mhb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_last_word,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_hash_value
);

    // A stalled result transaction holds its hash.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_value))
        else $error("result changed while stalled");

    // The core is busy for the cycle after each accepted word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("word accepted back to back");

    // A non-last word produces no hash while it is processed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_word |=>
            !$rose(m_valid) ##1 !$rose(m_valid) ##1 !$rose(m_valid)
            ##1 !$rose(m_valid))
        else $error("hash produced for a non-last word");

    // No result is pending right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind murmur_hash_64b_core mhb_checker u_mhb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_last_word  (s_last_word),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hash_value (m_hash_value)
);

`default_nettype wire
